FILE: rtl/tpra_pkg.sv
// ----------------------------------------------------------------------------
// Tick pacer rate averager package
// Widths, register indexes, reset values, sequencer states and the status
// group of the shared divider.
// ----------------------------------------------------------------------------
package tpra_pkg;

  localparam int unsigned TIME_W    = 63;
  localparam int unsigned RATE_W    = 10;
  localparam int unsigned PERIOD_W  = 30;
  localparam int unsigned DECAY_W   = 16;
  localparam int unsigned AVG_W     = 26;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned PROD_W    = AVG_W + FRAC_W + 1;
  localparam int unsigned S_DATA_W  = 64;
  localparam int unsigned M_DATA_W  = 144;
  localparam int unsigned M_USER_W  = 2;
  localparam int unsigned LANES     = 3;
  localparam int unsigned LANE_W    = 2;

  localparam int unsigned SAMPLE_INTERVAL_DEF = 20;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_SHORT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_MEDIUM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LONG   = 3'd4;

  localparam logic [RATE_W-1:0]   TARGET_RATE_RST  = 10'd20;
  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST  = 30'd50000000;
  localparam logic [DECAY_W-1:0]  DECAY_SHORT_RST  = 16'd64452;
  localparam logic [DECAY_W-1:0]  DECAY_MEDIUM_RST = 16'd65317;
  localparam logic [DECAY_W-1:0]  DECAY_LONG_RST   = 16'd65463;

  localparam logic [PERIOD_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [ACC_W-1:0]    ROUND_HALF = 64'd32768;
  localparam logic [FRAC_W:0]     ONE_Q16    = 17'h10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESET,
    ST_ELAPSED,
    ST_SPENT,
    ST_CMP,
    ST_OVER,
    ST_CAP,
    ST_DT,
    ST_DIVGO,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/tpra_div.sv
// ----------------------------------------------------------------------------
// Tick pacer rate averager divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpra_div #(
  parameter int unsigned NUM_W = 51,
  parameter int unsigned DEN_W = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_W-1:0]    dividend,
  input  logic [DEN_W-1:0]    divisor,
  output tpra_pkg::div_stat_t stat,
  output logic [NUM_W-1:0]    quotient
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = ~diff[DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

FILE: rtl/tick_pacer_rate_averager_core.sv
// A reset beat passes through RESET to OUT; a sleep through ELAPSED, SPENT and CMP to OUT; a taken
// tick adds OVER and CAP; a sampling tick adds DT, DIVGO, the divider wait and the lane updates.
// The divider's numerator width is 51 bits for an interval of 20. A zero sample time skips the
// divider. The divider gives one bit per cycle; the multiplier runs six times.
// One beat is in work at a time, so a new beat is accepted only after the last result leaves OUT.
// Reset restores register defaults, zeroes counters and debt and loads averages in Q.16.
// ----------------------------------------------------------------------------
// Tick pacer rate averager
// Paces tick attempts against the tick period with a catch-up debt and keeps
// one, five and fifteen minute moving averages of the measured tick rate.
// ----------------------------------------------------------------------------
module tick_pacer_rate_averager_core #(
  parameter int unsigned SAMPLE_INTERVAL = tpra_pkg::SAMPLE_INTERVAL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // now_ns [62:0], zero [63]
  input  logic [tpra_pkg::S_DATA_W-1:0]     s_tdata,
  // action [0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // sleep_ns [29:0], tick_number [61:30], avg_short [87:62],
  // avg_medium [113:88], avg_long [139:114], zero [143:140]
  output logic [tpra_pkg::M_DATA_W-1:0]     m_tdata,
  // tick_taken [0], rate_sampled [1]
  output logic [tpra_pkg::M_USER_W-1:0]     m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpra_pkg::PERIOD_W-1:0]     cfg_data
);

  localparam int unsigned INTERVAL_EFF = (SAMPLE_INTERVAL == 0) ? 1 : SAMPLE_INTERVAL;
  localparam int unsigned PHASE_W = (INTERVAL_EFF > 1) ? $clog2(INTERVAL_EFF) : 1;
  localparam longint unsigned RATE_NUM = 64'd1000000000 * INTERVAL_EFF * 64'd65536;
  localparam int unsigned NUM_W = $clog2(RATE_NUM + 1);

  tpra_pkg::state_t state, state_next;

  logic [tpra_pkg::RATE_W-1:0]   target_rate;
  logic [tpra_pkg::PERIOD_W-1:0] tick_period;
  logic [tpra_pkg::DECAY_W-1:0]  decay [tpra_pkg::LANES];

  logic [tpra_pkg::TIME_W-1:0]   last_tick;
  logic [tpra_pkg::TIME_W-1:0]   sample_start;
  logic [tpra_pkg::PERIOD_W-1:0] debt;
  logic [tpra_pkg::COUNT_W-1:0]  tick_count;
  logic [PHASE_W-1:0]            phase;
  logic [PHASE_W-1:0]            phase_next;
  logic [tpra_pkg::AVG_W-1:0]    avg [tpra_pkg::LANES];

  logic [tpra_pkg::TIME_W-1:0]   now_q;
  logic [tpra_pkg::ACC_W-1:0]    acc;
  logic [tpra_pkg::PROD_W-1:0]   prod;
  logic [tpra_pkg::AVG_W-1:0]    rate;
  logic [tpra_pkg::LANE_W-1:0]   lane;
  logic                          term;
  logic [tpra_pkg::PERIOD_W-1:0] res_sleep;
  logic                          res_taken;
  logic                          res_sampled;

  logic [tpra_pkg::AVG_W-1:0]    cap;
  logic                          out_free;

  logic [tpra_pkg::ACC_W-1:0]    add_a;
  logic [tpra_pkg::ACC_W-1:0]    add_b;
  logic                          add_sub;
  logic [tpra_pkg::ACC_W:0]      add_full;
  logic [tpra_pkg::ACC_W-1:0]    add_res;
  logic                          add_carry;

  logic [tpra_pkg::AVG_W-1:0]    mul_a;
  logic [tpra_pkg::FRAC_W:0]     mul_b;
  logic [tpra_pkg::DECAY_W-1:0]  lane_decay;

  logic                          div_start;
  tpra_pkg::div_stat_t           div_stat;
  logic [NUM_W-1:0]              div_quo;

  assign cap       = {target_rate, {tpra_pkg::FRAC_W{1'b0}}};
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == tpra_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign div_start = (state == tpra_pkg::ST_DIVGO) && (acc != '0);

  // Shared adder and subtractor; on subtraction the carry means a >= b.
  assign add_full  = {1'b0, add_a} + {1'b0, add_b ^ {tpra_pkg::ACC_W{add_sub}}}
                   + {{tpra_pkg::ACC_W{1'b0}}, add_sub};
  assign add_res   = add_full[tpra_pkg::ACC_W-1:0];
  assign add_carry = add_full[tpra_pkg::ACC_W];

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      tpra_pkg::ST_ELAPSED: begin
        add_a   = tpra_pkg::ACC_W'(now_q);
        add_b   = tpra_pkg::ACC_W'(last_tick);
        add_sub = 1'b1;
      end
      tpra_pkg::ST_SPENT: begin
        add_a = acc;
        add_b = tpra_pkg::ACC_W'(debt);
      end
      tpra_pkg::ST_CMP: begin
        add_a   = tpra_pkg::ACC_W'(tick_period);
        add_b   = acc;
        add_sub = 1'b1;
      end
      tpra_pkg::ST_OVER: begin
        add_a   = acc;
        add_b   = tpra_pkg::ACC_W'(tick_period);
        add_sub = 1'b1;
      end
      tpra_pkg::ST_CAP: begin
        add_a   = acc;
        add_b   = tpra_pkg::ACC_W'(tpra_pkg::NS_PER_SEC);
        add_sub = 1'b1;
      end
      tpra_pkg::ST_DT: begin
        add_a   = tpra_pkg::ACC_W'(now_q);
        add_b   = tpra_pkg::ACC_W'(sample_start);
        add_sub = 1'b1;
      end
      tpra_pkg::ST_ACC: begin
        add_a = term ? acc : tpra_pkg::ROUND_HALF;
        add_b = tpra_pkg::ACC_W'(prod);
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (lane)
      2'd0:    lane_decay = decay[0];
      2'd1:    lane_decay = decay[1];
      default: lane_decay = decay[2];
    endcase
    mul_a = term ? rate : avg[lane];
    mul_b = term ? (tpra_pkg::ONE_Q16 - {1'b0, lane_decay}) : {1'b0, lane_decay};
  end

  always_comb begin
    if (tick_count == {tpra_pkg::COUNT_W{1'b1}}) begin
      phase_next = '0;
    end else if (phase == PHASE_W'(INTERVAL_EFF - 1)) begin
      phase_next = '0;
    end else begin
      phase_next = phase + 1'b1;
    end
  end

  tpra_div #(
    .NUM_W (NUM_W),
    .DEN_W (tpra_pkg::TIME_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (NUM_W'(RATE_NUM)),
    .divisor  (acc[tpra_pkg::TIME_W-1:0]),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tpra_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = s_tuser ? tpra_pkg::ST_RESET : tpra_pkg::ST_ELAPSED;
        end
      end
      tpra_pkg::ST_RESET:   state_next = tpra_pkg::ST_OUT;
      tpra_pkg::ST_ELAPSED: state_next = tpra_pkg::ST_SPENT;
      tpra_pkg::ST_SPENT:   state_next = tpra_pkg::ST_CMP;
      tpra_pkg::ST_CMP: begin
        state_next = (add_carry && add_res != '0) ? tpra_pkg::ST_OUT : tpra_pkg::ST_OVER;
      end
      tpra_pkg::ST_OVER:    state_next = tpra_pkg::ST_CAP;
      tpra_pkg::ST_CAP: begin
        state_next = res_sampled ? tpra_pkg::ST_DT : tpra_pkg::ST_OUT;
      end
      tpra_pkg::ST_DT:      state_next = tpra_pkg::ST_DIVGO;
      tpra_pkg::ST_DIVGO: begin
        state_next = (acc == '0) ? tpra_pkg::ST_MUL : tpra_pkg::ST_DIV;
      end
      tpra_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = tpra_pkg::ST_MUL;
        end
      end
      tpra_pkg::ST_MUL:     state_next = tpra_pkg::ST_ACC;
      tpra_pkg::ST_ACC: begin
        if (term && lane == tpra_pkg::LANE_W'(tpra_pkg::LANES - 1)) begin
          state_next = tpra_pkg::ST_OUT;
        end else begin
          state_next = tpra_pkg::ST_MUL;
        end
      end
      tpra_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = tpra_pkg::ST_IDLE;
        end
      end
      default: state_next = tpra_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_rate <= tpra_pkg::TARGET_RATE_RST;
      tick_period <= tpra_pkg::TICK_PERIOD_RST;
      decay[0]    <= tpra_pkg::DECAY_SHORT_RST;
      decay[1]    <= tpra_pkg::DECAY_MEDIUM_RST;
      decay[2]    <= tpra_pkg::DECAY_LONG_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tpra_pkg::REG_TARGET_RATE:  target_rate <= cfg_data[tpra_pkg::RATE_W-1:0];
        tpra_pkg::REG_TICK_PERIOD:  tick_period <= cfg_data;
        tpra_pkg::REG_DECAY_SHORT:  decay[0] <= cfg_data[tpra_pkg::DECAY_W-1:0];
        tpra_pkg::REG_DECAY_MEDIUM: decay[1] <= cfg_data[tpra_pkg::DECAY_W-1:0];
        tpra_pkg::REG_DECAY_LONG:   decay[2] <= cfg_data[tpra_pkg::DECAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick    <= '0;
      sample_start <= '0;
      debt         <= '0;
      tick_count   <= '0;
      phase        <= '0;
      for (int i = 0; i < tpra_pkg::LANES; i++) begin
        avg[i] <= {tpra_pkg::TARGET_RATE_RST, {tpra_pkg::FRAC_W{1'b0}}};
      end
    end else begin
      case (state)
        tpra_pkg::ST_RESET: begin
          last_tick    <= now_q;
          sample_start <= now_q;
          debt         <= '0;
          tick_count   <= '0;
          phase        <= '0;
          for (int i = 0; i < tpra_pkg::LANES; i++) begin
            avg[i] <= cap;
          end
        end
        tpra_pkg::ST_CMP: begin
          if (add_carry && add_res != '0) begin
            debt <= '0;
          end
        end
        tpra_pkg::ST_OVER: begin
          last_tick  <= now_q;
          tick_count <= tick_count + 1'b1;
          phase      <= phase_next;
        end
        tpra_pkg::ST_CAP: begin
          debt <= (add_carry && add_res != '0) ? tpra_pkg::NS_PER_SEC
                                                : acc[tpra_pkg::PERIOD_W-1:0];
        end
        tpra_pkg::ST_DT: begin
          sample_start <= now_q;
        end
        tpra_pkg::ST_ACC: begin
          if (term) begin
            avg[lane] <= add_res[tpra_pkg::FRAC_W +: tpra_pkg::AVG_W];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tpra_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          now_q       <= s_tdata[tpra_pkg::TIME_W-1:0];
          res_sleep   <= '0;
          res_taken   <= 1'b0;
          res_sampled <= 1'b0;
        end
      end
      tpra_pkg::ST_ELAPSED: acc <= add_carry ? add_res : '0;
      tpra_pkg::ST_SPENT:   acc <= add_res;
      tpra_pkg::ST_CMP: begin
        if (add_carry && add_res != '0) begin
          res_sleep <= add_res[tpra_pkg::PERIOD_W-1:0];
        end
      end
      tpra_pkg::ST_OVER: begin
        acc         <= add_res;
        res_taken   <= 1'b1;
        res_sampled <= (phase == '0);
      end
      tpra_pkg::ST_DT:      acc <= add_carry ? add_res : '0;
      tpra_pkg::ST_DIVGO: begin
        lane <= '0;
        term <= 1'b0;
        if (acc == '0) begin
          rate <= cap;
        end
      end
      tpra_pkg::ST_DIV: begin
        if (div_stat.done) begin
          rate <= (div_quo < NUM_W'(cap)) ? div_quo[tpra_pkg::AVG_W-1:0] : cap;
        end
      end
      tpra_pkg::ST_MUL:     prod <= mul_a * mul_b;
      tpra_pkg::ST_ACC: begin
        if (term) begin
          term <= 1'b0;
          lane <= lane + 1'b1;
        end else begin
          acc  <= add_res;
          term <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == tpra_pkg::ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tpra_pkg::ST_OUT && out_free) begin
      m_tdata <= tpra_pkg::M_DATA_W'({avg[2], avg[1], avg[0], tick_count, res_sleep});
      m_tuser <= {res_sampled, res_taken};
    end
  end

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    (div_stat.busy || div_stat.done) |-> state == tpra_pkg::ST_DIV)
    else $error("divider active outside its wait state");

  a_sample_needs_tick: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("averages updated on a beat without a tick");

  a_tick_no_sleep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[tpra_pkg::PERIOD_W-1:0] == '0)
    else $error("taken tick reports a sleep time");

  a_debt_capped: assert property (@(posedge clk) disable iff (rst)
    debt <= tpra_pkg::NS_PER_SEC)
    else $error("catch-up debt above one second");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PHASE_W'(INTERVAL_EFF - 1))
    else $error("sample phase out of range");

endmodule
